FILE: hw/rtl/slab_pkg.sv
// Shared types and constants for the sRGB to CIELAB pixel converter.
// Holds the pixel structs, the matrix and white constants and the linearizing table.
// No dependencies.
package slab_pkg;

    localparam int WORK_BITS = 24;
    localparam int LIN_W     = 25;
    localparam int T_W       = 26;
    localparam int F_W       = 25;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_pixel_t;

    typedef struct packed {
        logic [10:0]        lightness;
        logic signed [11:0] green_red;
        logic signed [11:0] blue_yellow;
    } lab_pixel_t;

    typedef logic [LIN_W-1:0] lin_table_t [256];

    // sRGB to XYZ matrix in millionths
    localparam logic [19:0] MAT_COEF [3][3] = '{
        '{20'd412453, 20'd357580, 20'd180423},
        '{20'd212671, 20'd715160, 20'd72169},
        '{20'd19334,  20'd119193, 20'd950227}
    };

    // D65 white in millionths and its reciprocal scaled by 2^48
    localparam logic [20:0] WHITE_DIV [3] = '{21'd950470, 21'd1000000, 21'd1088830};
    localparam logic [28:0] WHITE_RECIP [3] = '{
        29'((64'd1 << 48) / 64'd950470),
        29'((64'd1 << 48) / 64'd1000000),
        29'((64'd1 << 48) / 64'd1088830)
    };

    localparam logic [T_W-1:0] T_LIN      = T_W'((64'd8856 << 24) / 64'd1000000);
    localparam logic [F_W-1:0] K16        = F_W'(((64'd16 << 24) + 64'd58) / 64'd116);
    localparam logic [30:0]    R_THOUSAND = 31'((64'd1 << 40) / 64'd1000);
    localparam logic [T_W-1:0] ONE_Q      = T_W'(64'd1 << 24);

    function automatic lin_table_t build_lin_table();
        lin_table_t tbl;
        longint unsigned cu, u, u2, lo, hi, mid, sq, qu, p5;
        for (int c = 0; c < 256; c++) begin
            cu = 64'(c);
            if (cu * 64'd100000 <= 64'd1031475) begin
                tbl[c] = LIN_W'((cu * 64'd100 * (64'd1 << 24) + 64'd164730) / 64'd329460);
            end else begin
                u  = ((64'd1000 * cu + 64'd14025) << 30) / 64'd269025;
                u2 = (u * u) >> 30;
                lo = 64'd0;
                hi = 64'd1 << 30;
                for (int it = 0; it < 32; it++) begin
                    if (lo < hi) begin
                        mid = (lo + hi + 64'd1) >> 1;
                        sq  = (mid * mid) >> 30;
                        qu  = (sq * sq) >> 30;
                        p5  = (qu * mid) >> 30;
                        if (p5 <= u2)
                            lo = mid;
                        else
                            hi = mid - 64'd1;
                    end
                end
                tbl[c] = LIN_W'((u2 * lo + (64'd1 << 35)) >> 36);
            end
        end
        return tbl;
    endfunction

    localparam lin_table_t LIN_TABLE = build_lin_table();

endpackage

FILE: hw/rtl/srgb_to_cielab_pixel.sv
// Top level of the sRGB to CIELAB (D65) pixel converter, fully pipelined.
// Depends on slab_pkg for pixel types, matrix constants and the linearizing table.
//
//   channel   signals                   width   direction
//   pixel     start, busy, pixel        24      in
//   result    done, lab                 35      out
//
// One pixel enters per cycle; results leave in the order of their start beats.
// Stages: ten front-end stages, the 24-stage cube root (one bit per stage), two back-end stages.
// busy is always low: the pipeline never stalls and the receiver cannot stall.
// Reset clears the valid bits only; no clearing pass is needed.
module srgb_to_cielab_pixel
    import slab_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  rgb_pixel_t pixel,
    output logic       done,
    output lab_pixel_t lab
);

    localparam int SHIFT = WORK_BITS - OUT_FRAC_BITS;
    localparam int LMAX_I = ((100 << OUT_FRAC_BITS) > 2047) ? 2047 : (100 << OUT_FRAC_BITS);
    localparam logic signed [35:0] LMAX = 36'(LMAX_I);
    localparam int ROOT_N = WORK_BITS;

    // valid chain: lin, prod, acc, q0, dprod, t, c1..c3, root entries, f1, out
    logic v_lin_reg, v_prod_reg, v_acc_reg, v_q_reg, v_dp_reg, v_t_reg;
    logic v_c1_reg, v_c2_reg, v_c3_reg;
    logic v_f1_reg, v_out_reg;

    logic [LIN_W-1:0] lin_reg  [3];
    logic [44:0]      prod_reg [3][3];
    logic [46:0]      acc_reg  [3];
    logic [46:0]      acc2_reg [3];
    logic [46:0]      acc3_reg [3];
    logic [T_W-1:0]   q0_reg   [3];
    logic [T_W-1:0]   q1_reg   [3];
    logic [46:0]      dp_reg   [3];
    logic [T_W-1:0]   t_reg    [3];

    logic [39:0]      n2_reg   [3];
    logic [T_W-1:0]   tc1_reg  [3];
    logic [31:0]      n2b_reg  [3];
    logic [22:0]      lq_reg   [3];
    logic [T_W-1:0]   tc2_reg  [3];
    logic [31:0]      n2c_reg  [3];
    logic [22:0]      lq2_reg  [3];
    logic [32:0]      lp_reg   [3];
    logic [T_W-1:0]   tc3_reg  [3];

    // root pipeline entries; entry 0 is fed by the linear-segment path
    logic             rt_v_reg   [ROOT_N+1];
    logic [T_W-1:0]   rt_t_reg   [ROOT_N+1][3];
    logic [23:0]      rt_r_reg   [ROOT_N+1][3];
    logic [47:0]      rt_s_reg   [ROOT_N+1][3];
    logic [F_W-1:0]   rt_fl_reg  [ROOT_N+1][3];
    logic             rt_lin_reg [ROOT_N+1][3];

    logic signed [35:0] lv_reg, av_reg, bv_reg;
    lab_pixel_t         lab_reg;

    logic [F_W-1:0]     f_fin [3];
    logic signed [35:0] fs    [3];
    logic signed [35:0] lv_r, av_r, bv_r;

    function automatic logic signed [35:0] rnd(input logic signed [35:0] v);
        logic signed [35:0] half;
        logic signed [35:0] m;
        half = 36'sd1 <<< (SHIFT - 1);
        if (v >= 0) begin
            rnd = (v + half) >>> SHIFT;
        end else begin
            m   = (-v + half) >>> SHIFT;
            rnd = -m;
        end
    endfunction

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_lin_reg  <= 1'b0;
            v_prod_reg <= 1'b0;
            v_acc_reg  <= 1'b0;
            v_q_reg    <= 1'b0;
            v_dp_reg   <= 1'b0;
            v_t_reg    <= 1'b0;
            v_c1_reg   <= 1'b0;
            v_c2_reg   <= 1'b0;
            v_c3_reg   <= 1'b0;
            rt_v_reg[0] <= 1'b0;
            v_f1_reg   <= 1'b0;
            v_out_reg  <= 1'b0;
        end
        else
        begin
            v_lin_reg  <= start;
            v_prod_reg <= v_lin_reg;
            v_acc_reg  <= v_prod_reg;
            v_q_reg    <= v_acc_reg;
            v_dp_reg   <= v_q_reg;
            v_t_reg    <= v_dp_reg;
            v_c1_reg   <= v_t_reg;
            v_c2_reg   <= v_c1_reg;
            v_c3_reg   <= v_c2_reg;
            rt_v_reg[0] <= v_c3_reg;
            v_f1_reg   <= rt_v_reg[ROOT_N];
            v_out_reg  <= v_f1_reg;
        end
    end

    // front end: linearize, matrix, divide by white, linear curve segment
    always_ff @(posedge clk)
    begin
        lin_reg[0] <= LIN_TABLE[pixel.red];
        lin_reg[1] <= LIN_TABLE[pixel.green];
        lin_reg[2] <= LIN_TABLE[pixel.blue];
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++)
                prod_reg[i][j] <= 45'(MAT_COEF[i][j] * lin_reg[j]);
            acc_reg[i]  <= 47'(prod_reg[i][0]) + 47'(prod_reg[i][1]) + 47'(prod_reg[i][2])
                           + 47'(WHITE_DIV[i] >> 1);
            // reciprocal estimate: quotient is q0 or q0 + 1
            q0_reg[i]   <= T_W'((60'(acc_reg[i][46:16]) * 60'(WHITE_RECIP[i])) >> 32);
            acc2_reg[i] <= acc_reg[i];
            dp_reg[i]   <= 47'(q0_reg[i] * WHITE_DIV[i]);
            q1_reg[i]   <= q0_reg[i];
            acc3_reg[i] <= acc2_reg[i];
            t_reg[i]    <= ((acc3_reg[i] - dp_reg[i]) >= 47'(WHITE_DIV[i]))
                           ? q1_reg[i] + T_W'(1) : q1_reg[i];

            n2_reg[i]   <= 40'(t_reg[i]) * 40'd7787 + 40'd500;
            tc1_reg[i]  <= t_reg[i];
            lq_reg[i]   <= 23'((63'(n2_reg[i][31:0]) * 63'(R_THOUSAND)) >> 40);
            n2b_reg[i]  <= n2_reg[i][31:0];
            tc2_reg[i]  <= tc1_reg[i];
            lp_reg[i]   <= 33'(lq_reg[i]) * 33'd1000;
            lq2_reg[i]  <= lq_reg[i];
            n2c_reg[i]  <= n2b_reg[i];
            tc3_reg[i]  <= tc2_reg[i];

            rt_t_reg[0][i]   <= tc3_reg[i];
            rt_r_reg[0][i]   <= 24'd0;
            rt_s_reg[0][i]   <= 48'd0;
            rt_lin_reg[0][i] <= (tc3_reg[i] <= T_LIN);
            rt_fl_reg[0][i]  <= ((33'(n2c_reg[i]) - lp_reg[i]) >= 33'd1000)
                                ? F_W'(lq2_reg[i]) + F_W'(1) + K16
                                : F_W'(lq2_reg[i]) + K16;
        end
    end

    // cube root, one result bit per stage, square kept exact by adds
    for (genvar k = 0; k < ROOT_N; k++) begin : g_root
        localparam int B = ROOT_N - 1 - k;
        logic [23:0] trial [3];
        logic [47:0] t2    [3];
        logic [47:0] cube  [3];
        logic        keep  [3];

        always_comb
        begin
            for (int i = 0; i < 3; i++) begin
                trial[i] = rt_r_reg[k][i] | (24'd1 << B);
                t2[i]    = rt_s_reg[k][i] + ({24'd0, rt_r_reg[k][i]} << (B + 1))
                           + (48'd1 << (2 * B));
                cube[i]  = 48'(t2[i][47:24] * trial[i]);
                keep[i]  = ({2'b00, cube[i][47:24]} <= rt_t_reg[k][i]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rt_v_reg[k+1] <= 1'b0;
            else
                rt_v_reg[k+1] <= rt_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++) begin
                rt_t_reg[k+1][i]   <= rt_t_reg[k][i];
                rt_fl_reg[k+1][i]  <= rt_fl_reg[k][i];
                rt_lin_reg[k+1][i] <= rt_lin_reg[k][i];
                rt_r_reg[k+1][i]   <= keep[i] ? trial[i] : rt_r_reg[k][i];
                rt_s_reg[k+1][i]   <= keep[i] ? t2[i] : rt_s_reg[k][i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            if (rt_lin_reg[ROOT_N][i])
                f_fin[i] = rt_fl_reg[ROOT_N][i];
            else if (rt_t_reg[ROOT_N][i] >= ONE_Q)
                f_fin[i] = F_W'(ONE_Q);
            else
                f_fin[i] = F_W'(rt_r_reg[ROOT_N][i]);
            fs[i] = $signed({11'd0, f_fin[i]});
        end
        lv_r = rnd(lv_reg);
        av_r = rnd(av_reg);
        bv_r = rnd(bv_reg);
    end

    // back end: scale to L, a, b, then round and saturate
    always_ff @(posedge clk)
    begin
        lv_reg <= fs[1] * 36'sd116 - (36'sd16 <<< WORK_BITS);
        av_reg <= (fs[0] - fs[1]) * 36'sd500;
        bv_reg <= (fs[1] - fs[2]) * 36'sd200;

        if (lv_r < 0)
            lab_reg.lightness <= 11'd0;
        else if (lv_r > LMAX)
            lab_reg.lightness <= 11'(LMAX);
        else
            lab_reg.lightness <= 11'(lv_r);

        if (av_r < -36'sd2048)
            lab_reg.green_red <= -12'sd2048;
        else if (av_r > 36'sd2047)
            lab_reg.green_red <= 12'sd2047;
        else
            lab_reg.green_red <= 12'(av_r);

        if (bv_r < -36'sd2048)
            lab_reg.blue_yellow <= -12'sd2048;
        else if (bv_r > 36'sd2047)
            lab_reg.blue_yellow <= 12'sd2047;
        else
            lab_reg.blue_yellow <= 12'(bv_r);
    end

    assign done = v_out_reg;
    assign lab  = lab_reg;

endmodule
